// ===== rtl/fpr_pkg.sv =====
package fpr_pkg;

  // Kept significand precision, implicit bit included
  localparam int unsigned KEPT_PRECISION = 11;
  localparam int unsigned FULL_PREC      = 24;
  localparam int unsigned DROP_BITS      = FULL_PREC - KEPT_PRECISION;

  localparam logic [FULL_PREC-1:0] DROP_MASK = FULL_PREC'((1 << DROP_BITS) - 1);
  localparam logic [FULL_PREC-1:0] HALF_ULP  = FULL_PREC'(1) << (DROP_BITS - 1);

  localparam logic [7:0] EXP_ALL_ONES = 8'hFF;

  // LCG constants
  localparam logic [31:0] LCG_MUL   = 32'd1103515245;
  localparam logic [31:0] LCG_ADD   = 32'd12345;
  localparam logic [31:0] RNG_RESET = 32'd12345;
  // Generator value that the first stochastic word will use
  localparam logic [31:0] RNG_FIRST =
    32'(64'(RNG_RESET) * 64'(LCG_MUL) + 64'(LCG_ADD));

  // Round mode codes
  localparam logic MODE_STOCHASTIC = 1'b0;
  localparam logic MODE_NEAREST    = 1'b1;

  typedef struct packed {
    logic special;   // NaN, infinity or zero: passed through
    logic use_rnd;   // random addend consumed, generator must step
  } fpr_flags_t;

endpackage

// ===== rtl/fpr_lcg.sv =====
module fpr_lcg import fpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  output logic [31:0] rnd
);

  // Holds the value the next consumer uses (reset to one step past the seed)
  logic [31:0] ahead;
  logic [31:0] ahead_next;

  assign ahead_next = ahead * LCG_MUL + LCG_ADD;
  assign rnd        = ahead;

  always_ff @(posedge clk) begin
    if (rst) begin
      ahead <= RNG_FIRST;
    end else if (step) begin
      ahead <= ahead_next;
    end
  end

endmodule

// ===== rtl/fpr_round.sv =====
module fpr_round import fpr_pkg::*; (
  input  logic                 mode,
  input  logic [31:0]          value,
  input  logic [DROP_BITS-1:0] rnd_low,
  output logic [31:0]          result,
  output fpr_flags_t           flags
);

  logic                 sgn;
  logic [7:0]           ex;
  logic                 sub;
  logic [FULL_PREC-1:0] sig;
  logic [FULL_PREC-1:0] addend;
  logic [FULL_PREC:0]   sum;
  logic [FULL_PREC-1:0] sh;
  logic [8:0]           ex_inc;
  logic [7:0]           ex_out;
  logic                 ovf;
  logic [FULL_PREC-1:0] kept;

  assign sgn = value[31];
  assign ex  = value[30:23];
  assign sub = (ex == 8'd0);
  assign sig = {~sub, value[22:0]};

  assign flags.special = (ex == EXP_ALL_ONES) || (value[30:0] == 31'd0);
  assign flags.use_rnd = !flags.special && (mode == MODE_STOCHASTIC);

  assign addend = (mode == MODE_NEAREST) ? HALF_ULP : FULL_PREC'(rnd_low);
  assign sum    = {1'b0, sig} + {1'b0, addend};

  // Carry out of the significand: renormalize by one
  assign ex_inc = {1'b0, ex} + 9'd1;
  assign sh     = sum[FULL_PREC] ? sum[FULL_PREC:1] : sum[FULL_PREC-1:0];
  assign ex_out = sum[FULL_PREC] ? ex_inc[7:0] : ex;
  assign ovf    = sum[FULL_PREC] && (ex_inc[8] || (ex_inc[7:0] == EXP_ALL_ONES));

  assign kept = sh & ~DROP_MASK;

  always_comb begin
    if (flags.special) begin
      result = value;
    end else if (ovf) begin
      result = {sgn, EXP_ALL_ONES, 23'd0};
    end else if (sub) begin
      // Carry into bit 23 lands in the exponent LSB: smallest normal
      result = {sgn, ex_out, 23'd0} | {8'd0, kept};
    end else begin
      result = {sgn, ex_out, kept[22:0]};
    end
  end

endmodule

// ===== rtl/fp32_to_fp16_precision_rounder.sv =====
// Binary32 precision rounder: each 32-bit word on value_bits is a binary32
// pattern whose significand is rounded to 11 bits (binary16 precision) while
// the binary32 format and full exponent range are kept. NaN, infinity and
// signed zero pass through untouched. round_mode 0 (reset) selects stochastic
// rounding: the low 13 bits of a 32-bit LCG (seed 12345, x*1103515245+12345)
// are added before truncation, and the generator steps once per finite
// nonzero word only. round_mode 1 adds half an ulp (ties away from zero).
// A word is taken every cycle while in_stall is low; it passes the input
// register (stage 1), then the result register, and shows on rounded_bits.
// The sustained rate of one word per cycle holds while out_stall does not
// hold the result word; the generator is one 32x32 constant multiply feeding
// its own register. Write round_mode only while the block is idle.
module fp32_to_fp16_precision_rounder import fpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        round_mode,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] value_bits,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] rounded_bits
);

  logic        mode;
  logic        s1_valid;
  logic [31:0] s1_value;
  logic        adv;        // result register free to load this cycle
  logic        s1_move;    // stage 1 word moves into the result register
  logic        lcg_step;
  logic [31:0] rnd_word;
  logic [31:0] result;
  fpr_flags_t  flags;

  // Config register is always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_STOCHASTIC;
    end else if (cfg_valid && cfg_ready) begin
      mode <= round_mode;
    end
  end

  // Pipeline control: stage 1 stalls only when the result word is held
  assign adv      = !out_valid || !out_stall;
  assign in_stall = s1_valid && !adv;
  assign s1_move  = s1_valid && adv;
  assign lcg_step = s1_move && flags.use_rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_value <= value_bits;
    end
  end

  fpr_lcg u_lcg (
    .clk  (clk),
    .rst  (rst),
    .step (lcg_step),
    .rnd  (rnd_word)
  );

  fpr_round u_round (
    .mode    (mode),
    .value   (s1_value),
    .rnd_low (rnd_word[DROP_BITS-1:0]),
    .result  (result),
    .flags   (flags)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rounded_bits <= result;
    end
  end

`ifndef SYNTHESIS
  // Generator holds unless a stochastic finite word leaves stage 1
  a_lcg_hold: assert property (@(posedge clk) disable iff (rst)
    !lcg_step |=> $stable(rnd_word))
    else $error("generator changed without a consuming word");

  // Nearest mode never consumes random bits
  a_nearest_no_step: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_NEAREST) |-> !lcg_step)
    else $error("generator stepped in nearest mode");

  // Special values come out unchanged
  a_special_pass: assert property (@(posedge clk) disable iff (rst)
    (s1_move && flags.special) |=> (rounded_bits == $past(s1_value)))
    else $error("special value altered");

  // Input side stalls only behind a full stage 1
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a held word");
`endif

endmodule
